// File: rtl/wsp_pkg.sv
package wsp_pkg;

	// Width of one screen coordinate and of the quotient that forms it.
	localparam int QUO_W = 32;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_X_FIRST  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_X_SECOND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_Y_FIRST  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_Y_SECOND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_W_FIRST  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_W_SECOND = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H     = 3'd7;

	localparam logic [15:0] SCREEN_W_RST = 16'd1920;
	localparam logic [15:0] SCREEN_H_RST = 16'd1080;

	// Saturation limits, by magnitude, for a positive and a negative result.
	localparam logic [QUO_W-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [QUO_W-1:0] SAT_NEG = 32'h8000_0000;

	typedef struct packed {
		logic signed [31:0] world_x;
		logic signed [31:0] world_y;
		logic signed [31:0] world_z;
	} wsp_in_t;

	typedef struct packed {
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
		logic               degenerate;
		logic               clipped;
	} wsp_out_t;

	// Per-item flags that ride along the divider; lane 0 is x, lane 1 is y.
	typedef struct packed {
		logic       degen;
		logic [1:0] neg;
		logic [1:0] ovf;
	} wsp_side_t;

	// Clip-space sum width: room for three 64-bit products and the
	// translation term scaled by 2^(2F), plus two guard bits.
	function automatic int clip_w(input int frac);
		int prod_w;
		prod_w = (2 * frac + 32 > 64) ? 2 * frac + 32 : 64;
		return prod_w + 2;
	endfunction

endpackage

// File: rtl/wsp_clip.sv
module wsp_clip #(
	parameter int COORD_FRAC_BITS = 16,
	localparam int CW = wsp_pkg::clip_w(COORD_FRAC_BITS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  valid,
	input  wsp_pkg::wsp_in_t      item,
	input  logic [5:0][63:0]      pairs,
	output logic                  clip_valid,
	output logic [2:0][CW-1:0]    clip_row
);
	import wsp_pkg::*;

	localparam int F2 = 2 * COORD_FRAC_BITS;

	logic signed [31:0]   coord [3];
	logic                 v_s1, v_s2, v_s3;
	logic signed [CW-1:0] row_s3 [3];

	assign coord[0] = item.world_x;
	assign coord[1] = item.world_y;
	assign coord[2] = item.world_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// One row per clip component: x, y, w.
	for (genvar r = 0; r < 3; r++) begin : g_row
		logic signed [31:0]   ma, mb, mc, md;
		logic signed [63:0]   pa_s1, pb_s1, pc_s1;
		logic signed [31:0]   off_s1;
		logic signed [CW-1:0] ab_s2, cd_s2;

		assign ma = pairs[2*r][63:32];
		assign mb = pairs[2*r][31:0];
		assign mc = pairs[2*r+1][63:32];
		assign md = pairs[2*r+1][31:0];

		always_ff @(posedge clk) begin
			if (en) begin
				pa_s1  <= coord[0] * ma;
				pb_s1  <= coord[1] * mb;
				pc_s1  <= coord[2] * mc;
				off_s1 <= md;
				ab_s2  <= CW'(pa_s1) + CW'(pb_s1);
				cd_s2  <= CW'(pc_s1) + (CW'(off_s1) <<< F2);
				row_s3[r] <= ab_s2 + cd_s2;
			end
		end

		assign clip_row[r] = row_s3[r];
	end

	assign clip_valid = v_s3;

endmodule

// File: rtl/wsp_scale.sv
module wsp_scale #(
	parameter int COORD_FRAC_BITS = 16,
	localparam int CW   = wsp_pkg::clip_w(COORD_FRAC_BITS),
	localparam int DW   = CW + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  valid,
	input  logic [2:0][CW-1:0]    clip_row,
	input  logic [1:0][15:0]      sizes,
	output logic                  div_valid,
	output wsp_pkg::wsp_side_t    div_side,
	output logic [1:0][DW-1:0]    div_rem,
	output logic [1:0][31:0]      div_nlo,
	output logic [DW-1:0]         div_den
);
	import wsp_pkg::*;

	localparam int NW   = CW + 1;
	localparam int PRW  = NW + 16;
	localparam int NNW  = PRW + COORD_FRAC_BITS + 1;
	localparam int CMPW = (NNW - 32 > DW) ? NNW - 32 : DW;

	logic signed [CW-1:0] cx, cy, cw;

	logic                 v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic signed [NW-1:0] num_s4 [2];
	logic signed [CW-1:0] cw_s4;
	logic                 degen_s4;
	logic [NW-1:0]        mag_s5 [2];
	logic [CW-1:0]        c_s5, c_s6, c_s7;
	wsp_side_t            side_s5, side_s6, side_s7, side_s8, side_s9;
	logic [47:0]          lo_s6 [2];
	logic [NW-17:0]       hi_s6 [2];
	logic [PRW-1:0]       prod_s7 [2];
	logic [NNW-1:0]       n_s8 [2];
	logic [DW-1:0]        den_s8, den_s9;
	logic [1:0][DW-1:0]   rem_s9;
	logic [1:0][31:0]     nlo_s9;

	assign cx = clip_row[0];
	assign cy = clip_row[1];
	assign cw = clip_row[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s4 <= valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s4: numerators cx + cw and cw - cy
			num_s4[0] <= NW'(cx) + NW'(cw);
			num_s4[1] <= NW'(cw) - NW'(cy);
			cw_s4     <= cw;
			degen_s4  <= (cw == '0);

			// s5: magnitudes and result signs
			c_s5          <= cw_s4[CW-1] ? CW'(-cw_s4) : CW'(cw_s4);
			side_s5.degen <= degen_s4;
			side_s5.ovf   <= '0;
			for (int l = 0; l < 2; l++) begin
				mag_s5[l]      <= num_s4[l][NW-1] ? NW'(-num_s4[l]) : NW'(num_s4[l]);
				side_s5.neg[l] <= num_s4[l][NW-1] ^ cw_s4[CW-1];
			end

			// s6: split multiply by the viewport size
			c_s6    <= c_s5;
			side_s6 <= side_s5;
			for (int l = 0; l < 2; l++) begin
				lo_s6[l] <= mag_s5[l][31:0] * sizes[l];
				hi_s6[l] <= mag_s5[l][NW-1:32] * sizes[l];
			end

			// s7: join the partial products
			c_s7    <= c_s6;
			side_s7 <= side_s6;
			for (int l = 0; l < 2; l++) begin
				prod_s7[l] <= (PRW'(hi_s6[l]) << 32) + PRW'(lo_s6[l]);
			end

			// s8: scale to fixed point and add half the divisor for rounding
			den_s8  <= {c_s7, 1'b0};
			side_s8 <= side_s7;
			for (int l = 0; l < 2; l++) begin
				n_s8[l] <= (NNW'(prod_s7[l]) << COORD_FRAC_BITS) + NNW'(c_s7);
			end

			// s9: overflow test and divider seed
			den_s9        <= den_s8;
			side_s9.degen <= side_s8.degen;
			side_s9.neg   <= side_s8.neg;
			for (int l = 0; l < 2; l++) begin
				side_s9.ovf[l] <= CMPW'(n_s8[l] >> 32) >= CMPW'(den_s8);
				rem_s9[l]      <= DW'(n_s8[l] >> 32);
				nlo_s9[l]      <= n_s8[l][31:0];
			end
		end
	end

	assign div_valid = v_s9;
	assign div_side  = side_s9;
	assign div_rem   = rem_s9;
	assign div_nlo   = nlo_s9;
	assign div_den   = den_s9;

endmodule

// File: rtl/wsp_div.sv
module wsp_div #(
	parameter int COORD_FRAC_BITS = 16,
	localparam int DW = wsp_pkg::clip_w(COORD_FRAC_BITS) + 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                valid,
	input  wsp_pkg::wsp_side_t                  side,
	input  logic [1:0][DW-1:0]                  rem,
	input  logic [1:0][31:0]                    nlo,
	input  logic [DW-1:0]                       den,
	output logic                                quo_valid,
	output wsp_pkg::wsp_side_t                  quo_side,
	output logic [1:0][wsp_pkg::QUO_W-1:0]      quo
);
	import wsp_pkg::*;

	// Index k holds what enters restoring step k; index QUO_W is the result.
	logic                    vld_s  [0:QUO_W];
	wsp_side_t               side_s [0:QUO_W];
	logic [1:0][QUO_W-1:0]   quo_s  [0:QUO_W];
	logic [1:0][DW-1:0]      rem_s  [0:QUO_W-1];
	logic [1:0][31:0]        nlo_s  [0:QUO_W-1];
	logic [DW-1:0]           den_s  [0:QUO_W-1];

	assign vld_s[0]  = valid;
	assign side_s[0] = side;
	assign quo_s[0]  = '0;
	assign rem_s[0]  = rem;
	assign nlo_s[0]  = nlo;
	assign den_s[0]  = den;

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [DW+1:0] trial [2];
		logic [1:0]    take;

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				trial[l] = {1'b0, rem_s[k][l], nlo_s[k][l][QUO_W-1-k]} - {2'b00, den_s[k]};
				take[l]  = !trial[l][DW+1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				for (int l = 0; l < 2; l++) begin
					quo_s[k+1][l] <= {quo_s[k][l][QUO_W-2:0], take[l]};
				end
			end
		end

		if (k < QUO_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					den_s[k+1] <= den_s[k];
					nlo_s[k+1] <= nlo_s[k];
					for (int l = 0; l < 2; l++) begin
						rem_s[k+1][l] <= take[l] ? trial[l][DW-1:0]
							: {rem_s[k][l][DW-2:0], nlo_s[k][l][QUO_W-1-k]};
					end
				end
			end
		end
	end

	assign quo_valid = vld_s[QUO_W];
	assign quo_side  = side_s[QUO_W];
	assign quo       = quo_s[QUO_W];

endmodule

// File: rtl/wsp_out.sv
module wsp_out (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid,
	input  wsp_pkg::wsp_side_t                side,
	input  logic [1:0][wsp_pkg::QUO_W-1:0]    quo,
	input  logic                              stall,
	output logic                              hold,
	output logic                              res_valid,
	output wsp_pkg::wsp_out_t                 res
);
	import wsp_pkg::*;

	logic [1:0][QUO_W-1:0] lim, mag, val;
	logic [1:0]            sat;
	wsp_out_t              res_d;
	wsp_out_t              out_q, skid_q;
	logic                  out_v_q, skid_v_q;
	logic                  push, free;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			lim[l] = side.neg[l] ? SAT_NEG : SAT_POS;
			sat[l] = side.ovf[l] || (quo[l] > lim[l]);
			mag[l] = sat[l] ? lim[l] : quo[l];
			val[l] = side.neg[l] ? QUO_W'(0) - mag[l] : mag[l];
		end
		res_d = '0;
		if (side.degen) begin
			res_d.degenerate = 1'b1;
		end else begin
			res_d.screen_x = val[0];
			res_d.screen_y = val[1];
			res_d.clipped  = |sat;
		end
	end

	// The pipeline only moves while the skid slot is empty.
	assign push = valid && !skid_v_q;
	assign free = !out_v_q || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (free) begin
			out_q <= skid_v_q ? skid_q : res_d;
		end else if (push) begin
			skid_q <= res_d;
		end
	end

	assign hold      = skid_v_q;
	assign res_valid = out_v_q;
	assign res       = out_q;

endmodule

// File: rtl/world_to_screen_projection_core.sv
// World-to-screen projection core: each item is one world point (Q16.16 by default, the
// fraction width set by COORD_FRAC_BITS) that is multiplied as a row vector with w = 1 by the
// view-projection matrix in the configuration registers, divided by clip w and mapped to the
// viewport, sx = (cx/cw + 1) * W/2 and sy = (1 - cy/cw) * H/2, rounded to nearest with ties away
// from zero and saturated to the signed 32-bit range (clipped flag). A zero clip w gives (0, 0)
// with the degenerate flag. The core takes one item per clock while in_stall is low: three stages
// form the clip row sums, six scale the numerators by the viewport size and set up the division,
// and 32 stages of a restoring divider, one quotient bit each, follow; an output register comes
// last. A two-entry output buffer lets the core keep accepting while a result waits; in_stall
// rises only when both entries are full.
// Write configuration only while no item is in flight.
module world_to_screen_projection_core #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  wsp_pkg::wsp_in_t                    in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output wsp_pkg::wsp_out_t                   out_data,
	input  logic                                cfg_wen,
	input  logic [wsp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [63:0]                         cfg_data
);
	import wsp_pkg::*;

	localparam int CW = clip_w(COORD_FRAC_BITS);
	localparam int DW = CW + 1;
	localparam logic [63:0] ONE = 64'(1) << COORD_FRAC_BITS;

	logic [5:0][63:0]      pair_q;
	logic [15:0]           width_q, height_q;

	logic                  en, hold;
	logic                  clip_valid;
	logic [2:0][CW-1:0]    clip_row;
	logic                  div_valid;
	wsp_side_t             div_side;
	logic [1:0][DW-1:0]    div_rem;
	logic [1:0][31:0]      div_nlo;
	logic [DW-1:0]         div_den;
	logic                  quo_valid;
	wsp_side_t             quo_side;
	logic [1:0][QUO_W-1:0] quo;

	// Configuration registers: matrix column pairs, then the viewport size.
	// Reset to identity on x, y and w.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q[0] <= ONE << 32;
			pair_q[1] <= '0;
			pair_q[2] <= ONE;
			pair_q[3] <= '0;
			pair_q[4] <= '0;
			pair_q[5] <= ONE;
			width_q   <= SCREEN_W_RST;
			height_q  <= SCREEN_H_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_COL_X_FIRST:  pair_q[0] <= cfg_data;
				CFG_COL_X_SECOND: pair_q[1] <= cfg_data;
				CFG_COL_Y_FIRST:  pair_q[2] <= cfg_data;
				CFG_COL_Y_SECOND: pair_q[3] <= cfg_data;
				CFG_COL_W_FIRST:  pair_q[4] <= cfg_data;
				CFG_COL_W_SECOND: pair_q[5] <= cfg_data;
				CFG_SCREEN_W:     width_q   <= cfg_data[15:0];
				CFG_SCREEN_H:     height_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Advance the whole pipeline unless the output skid entry is occupied;
	// hold is a register, so in_stall never depends on out_stall directly.
	assign en       = !hold;
	assign in_stall = hold;

	// Clip-space x, y and w.
	wsp_clip #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_clip (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.valid      (in_valid),
		.item       (in_data),
		.pairs      (pair_q),
		.clip_valid (clip_valid),
		.clip_row   (clip_row)
	);

	// Numerators, magnitudes, size scaling and divider seed.
	wsp_scale #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid     (clip_valid),
		.clip_row  (clip_row),
		.sizes     ({height_q, width_q}),
		.div_valid (div_valid),
		.div_side  (div_side),
		.div_rem   (div_rem),
		.div_nlo   (div_nlo),
		.div_den   (div_den)
	);

	// Two lanes of restoring division sharing the divisor 2*|cw|.
	wsp_div #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid     (div_valid),
		.side      (div_side),
		.rem       (div_rem),
		.nlo       (div_nlo),
		.den       (div_den),
		.quo_valid (quo_valid),
		.quo_side  (quo_side),
		.quo       (quo)
	);

	// Saturate, apply sign and flags, then buffer the result.
	wsp_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (quo_valid),
		.side      (quo_side),
		.quo       (quo),
		.stall     (out_stall),
		.hold      (hold),
		.res_valid (out_valid),
		.res       (out_data)
	);

endmodule
